>>> rtl/core/kplc_pkg.sv
`default_nettype none

package kplc_pkg;

  // default build values
  localparam int PIN_DIGITS_DEF = 4;
  localparam logic [15:0] WAIT_TICKS_RST = 16'd60;

  // key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_HASH       = 4'd10;
  localparam logic [3:0] KEY_STAR       = 4'd11;

  // item kinds
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOCKED   = 2'd0,
    MODE_UNLOCKED = 2'd1,
    MODE_OLD      = 2'd2,
    MODE_NEW      = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    MSG_NONE      = 4'd0,
    MSG_ENTER     = 4'd1,
    MSG_LOCKED    = 4'd2,
    MSG_DENIED    = 4'd3,
    MSG_GRANTED   = 4'd4,
    MSG_UNLOCKED  = 4'd5,
    MSG_INCORRECT = 4'd6,
    MSG_CORRECT   = 4'd7,
    MSG_OLD_PIN   = 4'd8,
    MSG_NEW_PIN   = 4'd9,
    MSG_CHANGED   = 4'd10
  } msg_t;

  typedef struct packed {
    logic       action;
    logic [3:0] key;
  } in_item_t;

  typedef struct packed {
    msg_t        message;
    logic        echo_valid;
    logic [3:0]  echo_digit;
    logic        door_locked;
    mode_t       mode_now;
    logic        waiting;
    logic        pin_saved;
    logic [15:0] new_pin;
  } out_item_t;

  // lock control state shared between the step logic and the state registers
  typedef struct packed {
    mode_t       mode;
    logic        solenoid;
    logic        hold_active;
    logic [15:0] hold_counter;
  } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/core/kplc_step.sv
`default_nettype none

module kplc_step #(
  parameter int PIN_DIGITS = kplc_pkg::PIN_DIGITS_DEF,
  parameter int CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1
) (
  input  kplc_pkg::in_item_t                item,
  input  logic [15:0]                       wait_ticks,
  input  kplc_pkg::ctrl_state_t             cur,
  input  logic [CW-1:0]                     count_cur,
  input  logic [PIN_DIGITS-1:0][3:0]        digits_cur,
  input  logic [PIN_DIGITS-1:0][3:0]        stored_cur,
  output kplc_pkg::ctrl_state_t             nxt,
  output logic [CW-1:0]                     count_next,
  output logic [PIN_DIGITS-1:0][3:0]        digits_next,
  output logic [PIN_DIGITS-1:0][3:0]        stored_next,
  output kplc_pkg::out_item_t               result
);
  import kplc_pkg::*;

  localparam logic [CW-1:0] LAST_POS = CW'(PIN_DIGITS - 1);

  logic [15:0] tick_count;
  logic        same;
  msg_t        msg;
  logic        echo_valid;
  logic [3:0]  echo_digit;
  logic        saved;

  assign tick_count = cur.hold_counter + 16'd1;

  // pin match, the last digit comes straight from the key being pressed
  always_comb begin
    same = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (i == PIN_DIGITS - 1) begin
        if (item.key != stored_cur[i]) same = 1'b0;
      end else begin
        if (digits_cur[i] != stored_cur[i]) same = 1'b0;
      end
    end
  end

  // next state and message for one item
  always_comb begin
    nxt         = cur;
    count_next  = count_cur;
    digits_next = digits_cur;
    stored_next = stored_cur;
    msg         = MSG_NONE;
    echo_valid  = 1'b0;
    echo_digit  = 4'd0;
    saved       = 1'b0;
    if (item.action == ACT_TICK) begin
      if (cur.hold_active) begin
        if (tick_count == wait_ticks) begin
          // hold over: show the mode prompt; unlocked releases the door
          nxt.hold_active  = 1'b0;
          nxt.hold_counter = 16'd0;
          count_next       = '0;
          unique case (cur.mode)
            MODE_LOCKED:   msg = MSG_ENTER;
            MODE_UNLOCKED: begin
              nxt.solenoid = 1'b0;
              msg          = MSG_UNLOCKED;
            end
            MODE_OLD:      msg = MSG_OLD_PIN;
            default:       msg = MSG_NEW_PIN;
          endcase
        end else begin
          nxt.hold_counter = tick_count;
        end
      end
    end else if (!cur.hold_active) begin
      if (item.key <= KEY_LAST_DIGIT && cur.mode != MODE_UNLOCKED) begin
        echo_valid = 1'b1;
        echo_digit = item.key;
        for (int i = 0; i < PIN_DIGITS; i++) begin
          if (count_cur == CW'(i)) digits_next[i] = item.key;
        end
        if (count_cur == LAST_POS) begin
          // full pin entered
          count_next      = '0;
          nxt.hold_active = 1'b1;
          unique case (cur.mode)
            MODE_NEW: begin
              stored_next = digits_next;
              saved       = 1'b1;
              msg         = MSG_CHANGED;
              nxt.mode    = cur.solenoid ? MODE_LOCKED : MODE_UNLOCKED;
            end
            MODE_OLD: begin
              if (same) begin
                msg      = MSG_CORRECT;
                nxt.mode = MODE_NEW;
              end else begin
                msg      = MSG_INCORRECT;
              end
            end
            default: begin
              if (same) begin
                msg      = MSG_GRANTED;
                nxt.mode = MODE_UNLOCKED;
              end else begin
                msg      = MSG_DENIED;
              end
            end
          endcase
        end else begin
          count_next = count_cur + CW'(1);
        end
      end else if (item.key == KEY_HASH) begin
        // enter or leave the pin change flow
        count_next = '0;
        if (cur.mode == MODE_LOCKED || cur.mode == MODE_UNLOCKED) begin
          nxt.mode = MODE_OLD;
          msg      = MSG_OLD_PIN;
        end else if (cur.solenoid) begin
          nxt.mode = MODE_LOCKED;
          msg      = MSG_ENTER;
        end else begin
          nxt.mode = MODE_UNLOCKED;
          msg      = MSG_UNLOCKED;
        end
      end else if (item.key == KEY_STAR && !cur.solenoid) begin
        // relock
        count_next      = '0;
        nxt.mode        = MODE_LOCKED;
        nxt.solenoid    = 1'b1;
        nxt.hold_active = 1'b1;
        msg             = MSG_LOCKED;
      end
    end
  end

  // result item, taken from the state after the item
  always_comb begin
    logic [15:0] pin;
    pin = 16'd0;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      pin = {pin[11:0], stored_next[i]};
    end
    result.message     = msg;
    result.echo_valid  = echo_valid;
    result.echo_digit  = echo_digit;
    result.door_locked = nxt.solenoid;
    result.mode_now    = nxt.mode;
    result.waiting     = nxt.hold_active;
    result.pin_saved   = saved;
    result.new_pin     = pin;
  end

endmodule

`default_nettype wire

>>> rtl/core/keypad_pin_lock_controller.sv
// Keypad PIN lock controller.
// Input channel (in_valid/in_ready/in_data) carries one keypad press or one
// timer tick per transfer; every input transfer yields exactly one result on
// the output channel (out_valid/out_ready/out_data), in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes wait_ticks; it
// is always ready and should only be written while the block is idle.
// The result is registered in out_data, or in the skid register on a stall.
// Throughput: one item per cycle while in_ready is high; the state update is
// a single pass of compare and mode logic ahead of the result register.
// A two-entry output stage (result register plus skid register) lets one
// more item in while a result waits; with both full, in_ready drops until
// the receiver takes a result.
// Reset: locked mode, solenoid engaged, digit count zero, stored PIN 0000,
// no hold running, wait_ticks 60, output stage empty.
`default_nettype none

module keypad_pin_lock_controller #(
  parameter int PIN_DIGITS = kplc_pkg::PIN_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kplc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kplc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import kplc_pkg::*;

  localparam int CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

  logic [15:0]                wait_ticks;
  ctrl_state_t                ctrl;
  ctrl_state_t                ctrl_next;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [PIN_DIGITS-1:0][3:0] digits;
  logic [PIN_DIGITS-1:0][3:0] digits_next;
  logic [PIN_DIGITS-1:0][3:0] stored;
  logic [PIN_DIGITS-1:0][3:0] stored_next;
  out_item_t                  result;
  logic                       skid_valid;
  out_item_t                  skid_data;
  logic                       in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_xfer   = in_valid && in_ready;

  kplc_step #(
    .PIN_DIGITS(PIN_DIGITS),
    .CW        (CW)
  ) u_step (
    .item       (in_data),
    .wait_ticks (wait_ticks),
    .cur        (ctrl),
    .count_cur  (count),
    .digits_cur (digits),
    .stored_cur (stored),
    .nxt        (ctrl_next),
    .count_next (count_next),
    .digits_next(digits_next),
    .stored_next(stored_next),
    .result     (result)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= WAIT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      wait_ticks <= cfg_data;
    end
  end

  // lock state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode         <= MODE_LOCKED;
      ctrl.solenoid     <= 1'b1;
      ctrl.hold_active  <= 1'b0;
      ctrl.hold_counter <= 16'd0;
      count             <= '0;
      stored            <= '0;
    end else if (in_xfer) begin
      ctrl   <= ctrl_next;
      count  <= count_next;
      stored <= stored_next;
    end
  end

  // entered digits need no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      digits <= digits_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_xfer) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_data   <= skid_data;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      out_data  <= result;
      out_valid <= 1'b1;
    end else begin
      out_valid <= 1'b0;
    end
  end

  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with result register empty");

  // digit position stays inside the pin
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PIN_DIGITS - 1))
    else $error("digit count beyond pin length");

  // tick counter only runs during a hold
  a_counter_idle: assert property (@(posedge clk) disable iff (rst)
    !ctrl.hold_active |-> ctrl.hold_counter == 16'd0)
    else $error("hold counter nonzero without a hold");

  // locked mode always has the solenoid engaged
  a_locked_engaged: assert property (@(posedge clk) disable iff (rst)
    ctrl.mode == MODE_LOCKED |-> ctrl.solenoid)
    else $error("locked mode with solenoid released");

  // unlocked mode with engaged solenoid only while the granted message holds
  a_grant_hold: assert property (@(posedge clk) disable iff (rst)
    (ctrl.mode == MODE_UNLOCKED && ctrl.solenoid) |-> ctrl.hold_active)
    else $error("door engaged in unlocked mode outside a hold");

endmodule

`default_nettype wire
